/* sv/turtle_plotter_macros.svh */
// Assertion macros shared by the turtle plotter RTL.
// No dependencies; include by bare file name.
`ifndef TURTLE_PLOTTER_MACROS_SVH
`define TURTLE_PLOTTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("turtle_plotter: check failed");

// Next-cycle implication, disabled during reset.
`define TP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("turtle_plotter: check failed");

`endif

/* sv/tp_pkg.sv */
// Shared types and constants for the turtle plotter.
// No dependencies.
`default_nettype none

package tp_pkg;

	localparam int GRID_DEF = 64;
	localparam int COORD_W  = 6;
	localparam int ROW_W    = 64;
	localparam int DIST_W   = 8;
	localparam int MODE_W   = 3;

	localparam logic [MODE_W-1:0] MODE_PEN_UP   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PEN_DOWN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TURN_R   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TURN_L   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MOVE     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PRINT    = 3'd5;

	localparam logic [1:0] HEAD_SECOND_UP = 2'd0;
	localparam logic [1:0] HEAD_FIRST_DN  = 2'd1;
	localparam logic [1:0] HEAD_SECOND_DN = 2'd2;
	localparam logic [1:0] HEAD_FIRST_UP  = 2'd3;

	typedef struct packed {
		logic pen_set;
		logic pen_clr;
		logic turn_r;
		logic turn_l;
		logic step;
	} tp_cmd_t;

endpackage

`default_nettype wire

/* sv/tp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/tp_turtle.sv */
// Turtle state (position, heading, pen) and the shared clamped step unit.
// Depends on tp_pkg.
`default_nettype none

module tp_turtle #(
	parameter int GRID = tp_pkg::GRID_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tp_pkg::tp_cmd_t              cmd,
	output logic      [tp_pkg::COORD_W-1:0]   pos_first,
	output logic      [tp_pkg::COORD_W-1:0]   pos_second,
	output logic                              pen_down
);

	localparam logic [tp_pkg::COORD_W-1:0] POS_MAX = tp_pkg::COORD_W'(GRID - 1);

	logic [1:0]                 heading_q;
	logic [tp_pkg::COORD_W-1:0] first_q;
	logic [tp_pkg::COORD_W-1:0] second_q;
	logic                       pen_q;
	logic [tp_pkg::COORD_W-1:0] first_nx;
	logic [tp_pkg::COORD_W-1:0] second_nx;

	always_comb begin
		first_nx  = first_q;
		second_nx = second_q;
		unique case (heading_q)
			tp_pkg::HEAD_SECOND_UP: if (second_q < POS_MAX) second_nx = second_q + 1'b1;
			tp_pkg::HEAD_FIRST_DN:  if (first_q != '0)      first_nx  = first_q - 1'b1;
			tp_pkg::HEAD_SECOND_DN: if (second_q != '0)     second_nx = second_q - 1'b1;
			tp_pkg::HEAD_FIRST_UP:  if (first_q < POS_MAX)  first_nx  = first_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			first_q   <= '0;
			second_q  <= '0;
			pen_q     <= 1'b0;
		end else begin
			if (cmd.pen_set) begin
				pen_q <= 1'b1;
			end else if (cmd.pen_clr) begin
				pen_q <= 1'b0;
			end
			if (cmd.turn_r) begin
				heading_q <= heading_q - 1'b1;
			end else if (cmd.turn_l) begin
				heading_q <= heading_q + 1'b1;
			end
			if (cmd.step) begin
				first_q  <= first_nx;
				second_q <= second_nx;
			end
		end
	end

	assign pos_first  = first_q;
	assign pos_second = second_q;
	assign pen_down   = pen_q;

endmodule

`default_nettype wire

/* sv/turtle_plotter.sv */
// Turtle plotter top level: command sequencer, canvas RAM, row output register.
// Depends on tp_pkg, tp_ram, tp_turtle and turtle_plotter_macros.svh.
//
//   channel  signals                               role
//   in       in_valid in_ready mode distance       one command per transfer
//   out      out_valid out_ready row_index         one canvas row per transfer
//            row_cells last_row
//
// Pen up, turns and unused modes end on acceptance; pen down marks the turtle's cell
//   (read, modify, write). Move makes distance-1 steps, or none if distance < 2;
//   each step is one pass through the shared step unit, then a mark when the pen is down.
// Print sends rows 0 to GRID-1 with one RAM read per row, holding on any out_ready stall.
// Reset clears the canvas at once through per-row valid bits.
// in_ready is high only while no command is in progress.
`default_nettype none
`include "turtle_plotter_macros.svh"

module turtle_plotter #(
	parameter int GRID = tp_pkg::GRID_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tp_pkg::MODE_W-1:0]   mode,
	input  wire logic [tp_pkg::DIST_W-1:0]   distance,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [tp_pkg::COORD_W-1:0]  row_index,
	output logic      [tp_pkg::ROW_W-1:0]    row_cells,
	output logic                             last_row
);

	localparam int AW = (GRID > 1) ? $clog2(GRID) : 1;
	localparam logic [tp_pkg::COORD_W-1:0] LAST_ROW = tp_pkg::COORD_W'(GRID - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_PRINT
	} state_t;

	state_t                      state_q;
	logic [tp_pkg::DIST_W-1:0]   steps_q;
	logic [tp_pkg::COORD_W-1:0]  r_q;
	logic [GRID-1:0]             row_valid_q;
	logic                        rd_valid_s1;
	logic                        out_valid_q;
	logic [tp_pkg::COORD_W-1:0]  row_index_q;
	logic [tp_pkg::ROW_W-1:0]    row_cells_q;
	logic                        last_row_q;

	tp_pkg::tp_cmd_t             cmd;
	logic [tp_pkg::COORD_W-1:0]  pos_first;
	logic [tp_pkg::COORD_W-1:0]  pos_second;
	logic                        pen_down;

	logic                        accept;
	logic                        out_free;
	logic                        load;
	logic                        load_last;
	logic [tp_pkg::COORD_W-1:0]  r_next;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [tp_pkg::ROW_W-1:0]    rd_data;
	logic [tp_pkg::ROW_W-1:0]    row_rd;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [tp_pkg::ROW_W-1:0]    wr_data;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign load      = (state_q == ST_PRINT) && out_free;
	assign load_last = load && (r_q == LAST_ROW);
	assign r_next    = r_q + 1'b1;
	assign row_rd    = rd_valid_s1 ? rd_data : '0;

	always_comb begin
		cmd         = '0;
		cmd.pen_clr = accept && (mode == tp_pkg::MODE_PEN_UP);
		cmd.pen_set = accept && (mode == tp_pkg::MODE_PEN_DOWN);
		cmd.turn_r  = accept && (mode == tp_pkg::MODE_TURN_R);
		cmd.turn_l  = accept && (mode == tp_pkg::MODE_TURN_L);
		cmd.step    = (state_q == ST_STEP);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		priority if (accept && (mode == tp_pkg::MODE_PRINT)) begin
			rd_en = 1'b1;
		end else if (state_q == ST_MARK_RD) begin
			rd_en   = 1'b1;
			rd_addr = pos_first[AW-1:0];
		end else if (load && !load_last) begin
			rd_en   = 1'b1;
			rd_addr = r_next[AW-1:0];
		end else begin
			rd_en = 1'b0;
		end
	end

	assign wr_en   = (state_q == ST_MARK_WR);
	assign wr_addr = pos_first[AW-1:0];
	assign wr_data = row_rd | (tp_pkg::ROW_W'(1) << pos_second);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			r_q         <= '0;
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			row_index_q <= '0;
			row_cells_q <= '0;
			last_row_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				row_index_q <= r_q;
				row_cells_q <= row_rd;
				last_row_q  <= load_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (mode == tp_pkg::MODE_PEN_DOWN) begin
							steps_q <= '0;
							state_q <= ST_MARK_RD;
						end else if (mode == tp_pkg::MODE_MOVE &&
								distance >= tp_pkg::DIST_W'(2)) begin
							steps_q <= distance - tp_pkg::DIST_W'(2);
							state_q <= ST_STEP;
						end else if (mode == tp_pkg::MODE_PRINT) begin
							r_q     <= '0;
							state_q <= ST_PRINT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STEP: begin
					priority if (pen_down) begin
						state_q <= ST_MARK_RD;
					end else if (steps_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						steps_q <= steps_q - 1'b1;
					end
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					if (steps_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						steps_q <= steps_q - 1'b1;
						state_q <= ST_STEP;
					end
				end
				ST_PRINT: begin
					if (load) begin
						if (load_last) begin
							state_q <= ST_IDLE;
						end else begin
							r_q <= r_next;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tp_turtle #(
		.GRID(GRID)
	) u_turtle (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.pos_first  (pos_first),
		.pos_second (pos_second),
		.pen_down   (pen_down)
	);

	tp_ram #(
		.WIDTH(tp_pkg::ROW_W),
		.DEPTH(GRID)
	) u_canvas (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_cells = row_cells_q;
	assign last_row  = last_row_q;

	`TP_ASSERT_NEXT(a_write_sets_valid, clk, arst_n, wr_en, row_valid_q[$past(wr_addr)])
	`TP_ASSERT_NEXT(a_last_row_ends_print, clk, arst_n, load_last, in_ready && last_row)
	`TP_ASSERT_SAME(a_mark_follows_read, clk, arst_n, wr_en, $past(state_q) == ST_MARK_RD)
	`TP_ASSERT_SAME(a_out_drop_after_transfer, clk, arst_n, $fell(out_valid_q), $past(out_ready))

endmodule

`default_nettype wire
